// ===== rtl/tlc_pkg.sv =====
// Shared types, constants and the power table function of the two-channel lux calculator.
package tlc_pkg;

  localparam int COUNT_W = 16;
  localparam int QUOT_W = 16;
  localparam int LUX_W = 11;
  localparam int POWER_TABLE_BITS_DEF = 10;
  localparam int COEF_FRACTION_BITS_DEF = 24;
  localparam logic [LUX_W-1:0] LUX_MAX = 11'd2047;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    REG_NONE = 3'd0,
    REG_LOW  = 3'd1,
    REG_MID  = 3'd2,
    REG_HIGH = 3'd3,
    REG_TOP  = 3'd4
  } region_t;

  // Everything about one item that rides alongside the ratio datapath.
  typedef struct packed {
    count_t  c0;
    count_t  c1;
    region_t region;
  } side_t;

  // Largest y with y <= 2^16 * (k / 2^tbits)^1.4, found by comparing y^5 with
  // the scaled seventh power of k in exact integer arithmetic.
  function automatic logic [15:0] pow_entry(input int k, input int tbits);
    logic [127:0] kk;
    logic [127:0] mm;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    int           e;
    e  = 80 - 7 * tbits;
    kk = 128'(k);
    for (int j = 0; j < 6; j++) begin
      kk = kk * 128'(k);
    end
    if (e > 0) begin
      kk = kk << e;
    end
    lo = 17'd0;
    hi = 17'd65536;
    for (int n = 0; n < 18; n++) begin
      if (lo < hi) begin
        mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
        mm  = 128'(mid);
        for (int j = 0; j < 4; j++) begin
          mm = mm * 128'(mid);
        end
        if (e < 0) begin
          mm = mm << (-e);
        end
        if (mm <= kk) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
    end
    return lo[15:0];
  endfunction

endpackage

// ===== rtl/tlc_divider.sv =====
// Region classification and a restoring divider that forms the Q0.16 ratio one bit per stage.
module tlc_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlc_pkg::count_t c0,
  input  tlc_pkg::count_t c1,
  output logic            out_valid,
  input  logic            out_ready,
  output tlc_pkg::side_t  out_side,
  output logic [tlc_pkg::QUOT_W-1:0] out_quot
);
  import tlc_pkg::*;

  localparam int STAGES = QUOT_W + 1;

  logic          vld    [STAGES];
  logic          rdy    [STAGES];
  logic [15:0]   rem_r  [STAGES];
  logic [QUOT_W-1:0] quot_r [STAGES];
  side_t         side_r [STAGES];

  logic    is_low;
  logic    is_mid;
  logic    is_high;
  logic    is_top;
  region_t region_next;

  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    if (k == STAGES - 1) begin : g_last
      assign rdy[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // Exact cross-multiplied borders at 0.50, 0.61, 0.80 and 1.30.
  assign is_low  = {c1, 1'b0} <= {1'b0, c0};
  assign is_mid  = (23'(c1) * 23'd100) <= (23'(c0) * 23'd61);
  assign is_high = (19'(c1) * 19'd5) <= (19'(c0) * 19'd4);
  assign is_top  = (20'(c1) * 20'd10) <= (20'(c0) * 20'd13);

  always_comb begin
    if (c0 == '0 || c1 == '0) begin
      region_next = REG_NONE;
    end else if (is_low) begin
      region_next = REG_LOW;
    end else if (is_mid) begin
      region_next = REG_MID;
    end else if (is_high) begin
      region_next = REG_HIGH;
    end else if (is_top) begin
      region_next = REG_TOP;
    end else begin
      region_next = REG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
    if (rdy[0]) begin
      side_r[0].c0     <= c0;
      side_r[0].c1     <= c1;
      side_r[0].region <= region_next;
      // Only the lowest region needs the ratio; the others divide zero.
      rem_r[0]  <= (region_next == REG_LOW) ? c1 : 16'd0;
      quot_r[0] <= '0;
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_step
    logic [16:0] trial;
    logic        take;

    assign trial = {rem_r[k-1], 1'b0};
    assign take  = trial >= {1'b0, side_r[k-1].c0};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
      if (rdy[k]) begin
        rem_r[k]  <= take ? 16'(trial - {1'b0, side_r[k-1].c0}) : trial[15:0];
        quot_r[k] <= {quot_r[k-1][QUOT_W-2:0], take};
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_side  = side_r[STAGES-1];
  assign out_quot  = quot_r[STAGES-1];

endmodule

// ===== rtl/tlc_power.sv =====
// Power table read and linear interpolation of the ratio raised to 1.4.
module tlc_power #(
  parameter int TABLE_BITS = tlc_pkg::POWER_TABLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlc_pkg::side_t in_side,
  input  logic [tlc_pkg::QUOT_W-1:0] quot,
  output logic           out_valid,
  input  logic           out_ready,
  output tlc_pkg::side_t out_side,
  output logic [15:0]    power
);
  import tlc_pkg::*;

  localparam int STAGES = 3;
  localparam int S = QUOT_W - TABLE_BITS;
  // The ratio never exceeds one half, so only the lower half of the table is reachable.
  localparam int ROM_DEPTH = (1 << (TABLE_BITS - 1)) + 2;

  typedef logic [15:0] rom_t [ROM_DEPTH];

  function automatic rom_t rom_fill();
    rom_t r;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      r[k] = pow_entry(k, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = rom_fill();

  logic vld [STAGES];
  logic rdy [STAGES];

  logic [TABLE_BITS-1:0] idx;
  logic [TABLE_BITS-1:0] idx_up;

  logic [15:0]   a0;
  logic [15:0]   b0;
  logic [S-1:0]  f0;
  side_t         side0;
  logic [15:0]   a1;
  logic [16+S-1:0] prod1;
  side_t         side1;
  logic [15:0]   p2;
  side_t         side2;

  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    if (k == STAGES - 1) begin : g_last
      assign rdy[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];
  assign idx      = quot[QUOT_W-1:S];
  assign idx_up   = idx + TABLE_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
      vld[1] <= 1'b0;
      vld[2] <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
      if (rdy[2]) begin
        vld[2] <= vld[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a0    <= ROM[idx];
      b0    <= ROM[idx_up];
      f0    <= quot[S-1:0];
      side0 <= in_side;
    end
    if (rdy[1]) begin
      prod1 <= (16+S)'(b0 - a0) * (16+S)'(f0);
      a1    <= a0;
      side1 <= side0;
    end
    if (rdy[2]) begin
      p2    <= a1 + 16'(prod1 >> S);
      side2 <= side1;
    end
  end

  assign out_valid = vld[2];
  assign out_side  = side2;
  assign power     = p2;

endmodule

// ===== rtl/tlc_lux.sv =====
// Coefficient products, region difference, scaling and saturation to whole lux.
module tlc_lux #(
  parameter int COEF_BITS = tlc_pkg::COEF_FRACTION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlc_pkg::side_t in_side,
  input  logic [15:0]    power,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [tlc_pkg::LUX_W-1:0] lux
);
  import tlc_pkg::*;

  localparam int STAGES = 4;
  localparam int CW = COEF_BITS;
  localparam int PW = CW + 16;
  localparam int DL = (PW + 1) / 2;
  localparam int DH = PW - DL;
  localparam int SW = PW + 16;

  // Coefficients rounded to nearest, ties up.
  localparam logic [63:0] A1_FULL = ((64'd304 << CW) + 64'd5000) / 64'd10000;
  localparam logic [63:0] B1_FULL = ((64'd62 << CW) + 64'd500) / 64'd1000;
  localparam logic [63:0] A2_FULL = ((64'd224 << CW) + 64'd5000) / 64'd10000;
  localparam logic [63:0] B2_FULL = ((64'd31 << CW) + 64'd500) / 64'd1000;
  localparam logic [63:0] A3_FULL = ((64'd128 << CW) + 64'd5000) / 64'd10000;
  localparam logic [63:0] B3_FULL = ((64'd153 << CW) + 64'd5000) / 64'd10000;
  localparam logic [63:0] A4_FULL = ((64'd146 << CW) + 64'd50000) / 64'd100000;
  localparam logic [63:0] B4_FULL = ((64'd112 << CW) + 64'd50000) / 64'd100000;

  localparam logic [CW-1:0] A1 = A1_FULL[CW-1:0];
  localparam logic [CW-1:0] B1 = B1_FULL[CW-1:0];
  localparam logic [CW-1:0] A2 = A2_FULL[CW-1:0];
  localparam logic [CW-1:0] B2 = B2_FULL[CW-1:0];
  localparam logic [CW-1:0] A3 = A3_FULL[CW-1:0];
  localparam logic [CW-1:0] B3 = B3_FULL[CW-1:0];
  localparam logic [CW-1:0] A4 = A4_FULL[CW-1:0];
  localparam logic [CW-1:0] B4 = B4_FULL[CW-1:0];

  localparam logic [PW-1:0] A1_SCALED = PW'(A1) << 16;

  function automatic logic [LUX_W-1:0] lux_sat(input logic [15:0] v);
    return (v > 16'(LUX_MAX)) ? LUX_MAX : v[LUX_W-1:0];
  endfunction

  logic vld [STAGES];
  logic rdy [STAGES];

  logic [CW-1:0] coef_x;
  logic [CW-1:0] coef_y;
  logic [15:0]   opnd_y;

  logic [PW-1:0] mul_x;
  logic [PW-1:0] mul_y;
  count_t        c0_0;
  logic          low0;

  logic [PW-1:0] dval1;
  logic [15:0]   lin1;
  count_t        c0_1;
  logic          low1;

  logic [DL+15:0] part_lo;
  logic [DH+15:0] part_hi;
  logic [15:0]    lin2;
  logic           low2;

  logic [SW-1:0]    total;
  logic [15:0]      low_lux;
  logic [LUX_W-1:0] lux3;

  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    if (k == STAGES - 1) begin : g_last
      assign rdy[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // The lowest region reuses the second product for B times the interpolated power.
  always_comb begin
    case (in_side.region)
      REG_LOW: begin
        coef_x = '0;
        coef_y = B1;
        opnd_y = power;
      end
      REG_MID: begin
        coef_x = A2;
        coef_y = B2;
        opnd_y = in_side.c1;
      end
      REG_HIGH: begin
        coef_x = A3;
        coef_y = B3;
        opnd_y = in_side.c1;
      end
      REG_TOP: begin
        coef_x = A4;
        coef_y = B4;
        opnd_y = in_side.c1;
      end
      default: begin
        coef_x = '0;
        coef_y = '0;
        opnd_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
      vld[1] <= 1'b0;
      vld[2] <= 1'b0;
      vld[3] <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
      if (rdy[2]) begin
        vld[2] <= vld[1];
      end
      if (rdy[3]) begin
        vld[3] <= vld[2];
      end
    end
  end

  assign total   = (SW'(part_hi) << DL) + SW'(part_lo);
  assign low_lux = total[SW-1:CW+16];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mul_x <= PW'(coef_x) * PW'(in_side.c0);
      mul_y <= PW'(coef_y) * PW'(opnd_y);
      c0_0  <= in_side.c0;
      low0  <= (in_side.region == REG_LOW);
    end
    if (rdy[1]) begin
      // A non-positive difference gives zero lux in every region.
      dval1 <= (A1_SCALED > mul_y) ? (A1_SCALED - mul_y) : '0;
      lin1  <= (mul_x > mul_y) ? 16'((mul_x - mul_y) >> CW) : 16'd0;
      c0_1  <= c0_0;
      low1  <= low0;
    end
    if (rdy[2]) begin
      part_lo <= (DL+16)'(dval1[DL-1:0]) * (DL+16)'(c0_1);
      part_hi <= (DH+16)'(dval1[PW-1:DL]) * (DH+16)'(c0_1);
      lin2    <= lin1;
      low2    <= low1;
    end
    if (rdy[3]) begin
      lux3 <= low2 ? lux_sat(low_lux) : lux_sat(lin2);
    end
  end

  assign out_valid = vld[3];
  assign lux       = lux3;

endmodule

// ===== rtl/two_channel_lux_calculator.sv =====
// Top level of the two-channel lux calculator: divider, power interpolation and lux stages.
// Stages from input transfer to result valid: 17 classify and divider stages, 3 power-table
// stages, 4 product and scaling stages.
// Throughput: one item per cycle while out_ready is high; a stage holds its item while the
// next one is full; empty stages keep filling while a result waits at the output register.
// Reset: synchronous, active high rst clears all stage valid bits; data is not reset.
module two_channel_lux_calculator #(
  parameter int POWER_TABLE_BITS = tlc_pkg::POWER_TABLE_BITS_DEF,
  parameter int COEF_FRACTION_BITS = tlc_pkg::COEF_FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tlc_pkg::count_t broadband_count,
  input  tlc_pkg::count_t infrared_count,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [tlc_pkg::LUX_W-1:0] lux
);
  import tlc_pkg::*;

  logic              div_valid;
  logic              div_ready;
  side_t             div_side;
  logic [QUOT_W-1:0] div_quot;

  logic        pow_valid;
  logic        pow_ready;
  side_t       pow_side;
  logic [15:0] pow_value;

  tlc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .c0        (broadband_count),
    .c1        (infrared_count),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_side  (div_side),
    .out_quot  (div_quot)
  );

  tlc_power #(
    .TABLE_BITS (POWER_TABLE_BITS)
  ) u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_side   (div_side),
    .quot      (div_quot),
    .out_valid (pow_valid),
    .out_ready (pow_ready),
    .out_side  (pow_side),
    .power     (pow_value)
  );

  tlc_lux #(
    .COEF_BITS (COEF_FRACTION_BITS)
  ) u_lux (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pow_valid),
    .in_ready  (pow_ready),
    .in_side   (pow_side),
    .power     (pow_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lux       (lux)
  );

endmodule

// ===== dv/lux_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts lux for every input transfer and compares it with every output transfer.
module lux_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  tlc_pkg::count_t           broadband_count,
  input  tlc_pkg::count_t           infrared_count,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [tlc_pkg::LUX_W-1:0] lux,
  output int                        errors,
  output int                        outstanding
);
  import tlc_pkg::*;

  localparam int TBITS = POWER_TABLE_BITS_DEF;
  localparam int FBITS = COEF_FRACTION_BITS_DEF;
  localparam int FRAC_BITS = 16 - TBITS;
  localparam int POW_ENTRIES = (1 << TBITS) + 1;

  logic [16:0]      pow14_table [POW_ENTRIES];
  logic [LUX_W-1:0] pending_lux [$];
  int               fail_count = 0;
  int               waiting = 0;

  assign errors = fail_count;
  assign outstanding = waiting;

  // Entry k is the largest y with y^5 <= 2^80 * (k / 2^TBITS)^7. The entries never
  // decrease, so each search starts from the previous answer.
  initial begin : build_pow14
    logic [127:0] target;
    logic [127:0] base;
    logic [127:0] cand;
    logic [16:0]  y;
    bit           grow;
    int           up;
    int           down;
    up = (80 - 7 * TBITS > 0) ? 80 - 7 * TBITS : 0;
    down = (80 - 7 * TBITS < 0) ? 7 * TBITS - 80 : 0;
    y = 17'd0;
    for (int k = 0; k < POW_ENTRIES; k++) begin
      target = 128'd1;
      for (int j = 0; j < 7; j++) begin
        target = target * 128'(k);
      end
      target = target << up;
      grow = 1'b1;
      while (grow && y < 17'd65536) begin
        base = 128'(y) + 128'd1;
        cand = base;
        for (int j = 0; j < 4; j++) begin
          cand = cand * base;
        end
        cand = cand << down;
        if (cand <= target) begin
          y = y + 17'd1;
        end else begin
          grow = 1'b0;
        end
      end
      pow14_table[k] = y;
    end
  end

  function automatic longint unsigned coef(input int num, input int den);
    longint unsigned n;
    n = num;
    return ((n << FBITS) + den / 2) / den;
  endfunction

  function automatic logic [LUX_W-1:0] predict_lux(input count_t c0, input count_t c1);
    region_t         band;
    longint unsigned b0;
    longint unsigned b1;
    longint unsigned q;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned p;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned whole;
    int              shift;
    b0 = c0;
    b1 = c1;
    band = REG_NONE;
    if (b0 != 0 && b1 != 0) begin
      if (2 * b1 <= b0) begin
        band = REG_LOW;
      end else if (100 * b1 <= 61 * b0) begin
        band = REG_MID;
      end else if (5 * b1 <= 4 * b0) begin
        band = REG_HIGH;
      end else if (10 * b1 <= 13 * b0) begin
        band = REG_TOP;
      end
    end
    pos = 0;
    neg = 0;
    shift = FBITS;
    case (band)
      REG_LOW: begin
        // Ratio in Q0.16, then r^1.4 by linear interpolation between table entries.
        q = (b1 << 16) / b0;
        idx = q >> FRAC_BITS;
        frac = q & ((64'd1 << FRAC_BITS) - 1);
        if (idx >= POW_ENTRIES - 1) begin
          p = pow14_table[POW_ENTRIES-1];
        end else begin
          p = pow14_table[idx] +
              ((64'(pow14_table[idx+1] - pow14_table[idx]) * frac) >> FRAC_BITS);
        end
        pos = coef(304, 10000) * b0 * 65536;
        neg = coef(62, 1000) * b0 * p;
        shift = FBITS + 16;
      end
      REG_MID: begin
        pos = coef(224, 10000) * b0;
        neg = coef(31, 1000) * b1;
      end
      REG_HIGH: begin
        pos = coef(128, 10000) * b0;
        neg = coef(153, 10000) * b1;
      end
      REG_TOP: begin
        pos = coef(146, 100000) * b0;
        neg = coef(112, 100000) * b1;
      end
      default: ;
    endcase
    whole = (pos > neg) ? (pos - neg) >> shift : 64'd0;
    return (whole > LUX_MAX) ? LUX_MAX : whole[LUX_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [LUX_W-1:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_lux.push_back(predict_lux(broadband_count, infrared_count));
      end
      if (out_valid && out_ready) begin
        if (pending_lux.size() == 0) begin
          $error("lux: result %0d arrived with no transfer pending", lux);
          fail_count++;
        end else begin
          want = pending_lux.pop_front();
          if (want !== lux) begin
            $error("lux mismatch: expected %0d, actual %0d", want, lux);
            fail_count++;
          end
        end
      end
      waiting = pending_lux.size();
    end
  end

endmodule

// ===== dv/tb_two_channel_lux_calculator.sv =====
`timescale 1ns / 100ps
// Testbench top for the two-channel lux calculator: stimulus, stall control and verdict.
module tb_two_channel_lux_calculator;
  import tlc_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASES = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SQUEEZE_CYCLES = 120;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  count_t           broadband_count = '0;
  count_t           infrared_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LUX_W-1:0] lux;
  int               errors;
  int               outstanding;
  int               send_gap = 0;
  int               recv_stall = 0;
  int               squeeze_req = 0;
  int               cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  two_channel_lux_calculator i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .broadband_count (broadband_count),
    .infrared_count  (infrared_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .lux             (lux)
  );

  lux_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .broadband_count (broadband_count),
    .infrared_count  (infrared_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .lux             (lux),
    .errors          (errors),
    .outstanding     (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request so the pipeline backs up.
  initial begin : receiver
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req != seen) begin
        seen = squeeze_req;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_counts(input count_t c0, input count_t c1);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    broadband_count <= c0;
    infrared_count <= c1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_counts(output count_t c0, output count_t c1);
    longint unsigned b0;
    longint unsigned b1;
    int              num;
    int              den;
    case ($urandom_range(9))
      0, 1: begin
        b0 = $urandom_range(65535);
        b1 = $urandom_range(65535);
      end
      2: begin
        b0 = $urandom_range(40);
        b1 = $urandom_range(60);
      end
      3: begin
        // Land on or next to one of the region borders.
        case ($urandom_range(3))
          0: begin num = 1; den = 2; end
          1: begin num = 61; den = 100; end
          2: begin num = 4; den = 5; end
          default: begin num = 13; den = 10; end
        endcase
        b0 = $urandom_range(1, 50000);
        b1 = b0 * num / den + $urandom_range(2);
        b1 = (b1 > 0) ? b1 - 1 : 0;
      end
      default: begin
        b0 = ($urandom & 16'hFFFF) >> $urandom_range(15);
        b1 = b0 * $urandom_range(1400) / 1000;
      end
    endcase
    c0 = (b0 > 65535) ? 16'hFFFF : b0[15:0];
    c1 = (b1 > 65535) ? 16'hFFFF : b1[15:0];
  endtask

  initial begin : stimulus
    count_t c0;
    count_t c1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_counts(16'd0, 16'd0);
    send_counts(16'd0, 16'd65535);
    send_counts(16'd65535, 16'd0);
    send_counts(16'd1, 16'd0);
    send_counts(16'd1, 16'd1);
    send_counts(16'd65535, 16'd65535);
    send_counts(16'd65535, 16'd1);
    send_counts(16'd2, 16'd1);
    send_counts(16'd3, 16'd1);
    send_counts(16'd1000, 16'd500);
    send_counts(16'd1000, 16'd501);
    send_counts(16'd100, 16'd61);
    send_counts(16'd100, 16'd62);
    send_counts(16'd1000, 16'd800);
    send_counts(16'd1000, 16'd801);
    send_counts(16'd1000, 16'd1300);
    send_counts(16'd1000, 16'd1301);
    send_counts(16'd10, 16'd13);
    send_counts(16'd10, 16'd14);
    send_counts(16'd65535, 16'd32767);
    send_counts(16'd65535, 16'd32768);
    send_counts(16'd40000, 16'd52000);
    send_counts(16'd50411, 16'd65535);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin send_gap = 0; recv_stall <= 0; end
        1: begin send_gap = 77; recv_stall <= 0; end
        2: begin send_gap = 0; recv_stall <= 77; end
        default: begin send_gap = 10; recv_stall <= 10; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (phase == 0 && n == 40) begin
          squeeze_req <= squeeze_req + 1;
        end
        pick_counts(c0, c1);
        send_counts(c0, c1);
      end
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tlc_pkg.sv
rtl/tlc_divider.sv
rtl/tlc_power.sv
rtl/tlc_lux.sv
rtl/two_channel_lux_calculator.sv
dv/lux_checker.sv
dv/tb_two_channel_lux_calculator.sv
